/* src/dscw_pkg.sv */
// ----------------------------------------------------------------------------
// dscw_pkg
// Item types, drive state codes, control word masks and transition tables.
// ----------------------------------------------------------------------------
package dscw_pkg;

  localparam logic [3:0] ST_START      = 4'd0;
  localparam logic [3:0] ST_NOT_READY  = 4'd1;
  localparam logic [3:0] ST_SOD        = 4'd2;
  localparam logic [3:0] ST_READY      = 4'd3;
  localparam logic [3:0] ST_SWITCHED   = 4'd4;
  localparam logic [3:0] ST_OPEN       = 4'd5;
  localparam logic [3:0] ST_QSTOP      = 4'd6;
  localparam logic [3:0] ST_FAULT_REAC = 4'd7;
  localparam logic [3:0] ST_FAULT      = 4'd8;

  localparam logic [15:0] CW_SWITCH_ON   = 16'h0001;
  localparam logic [15:0] CW_EN_VOLTAGE  = 16'h0002;
  localparam logic [15:0] CW_QUICK_STOP  = 16'h0004;
  localparam logic [15:0] CW_EN_OP       = 16'h0008;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;

  typedef struct packed {
    logic [15:0] control_word;
    logic [3:0]  from_state;
    logic [3:0]  target_state;
    logic        step_mode;
  } req_t;

  typedef struct packed {
    logic [15:0] new_control_word;
    logic [3:0]  hop_state;
    logic        ok;
  } rsp_t;

  typedef struct packed {
    logic       found;
    logic [3:0] state;
  } hop_t;

  typedef struct packed {
    logic        found;
    logic [15:0] set_mask;
    logic [15:0] clr_mask;
  } trans_t;

  function automatic hop_t hop_enable(input logic [3:0] from);
    hop_t h;
    h.found = 1'b1;
    unique case (from)
      ST_START:      h.state = ST_NOT_READY;
      ST_NOT_READY:  h.state = ST_SOD;
      ST_SOD:        h.state = ST_READY;
      ST_READY:      h.state = ST_SWITCHED;
      ST_SWITCHED:   h.state = ST_OPEN;
      ST_OPEN:       h.state = ST_OPEN;
      ST_QSTOP:      h.state = ST_OPEN;
      ST_FAULT_REAC: h.state = ST_FAULT;
      ST_FAULT:      h.state = ST_SOD;
      default: begin
        h.found = 1'b0;
        h.state = ST_START;
      end
    endcase
    return h;
  endfunction

  function automatic hop_t hop_disable(input logic [3:0] from);
    hop_t h;
    h.found = 1'b1;
    unique case (from)
      ST_START:      h.state = ST_NOT_READY;
      ST_NOT_READY:  h.state = ST_SOD;
      ST_SOD:        h.state = ST_SOD;
      ST_READY:      h.state = ST_SOD;
      ST_SWITCHED:   h.state = ST_READY;
      ST_OPEN:       h.state = ST_SWITCHED;
      ST_FAULT_REAC: h.state = ST_FAULT;
      ST_FAULT:      h.state = ST_SOD;
      default: begin
        h.found = 1'b0;
        h.state = ST_START;
      end
    endcase
    return h;
  endfunction

  function automatic trans_t trans_lookup(input logic [3:0] from, input logic [3:0] to);
    trans_t t;
    t.found    = 1'b1;
    t.set_mask = '0;
    t.clr_mask = '0;
    unique case ({from, to})
      {ST_READY, ST_SOD}, {ST_OPEN, ST_SOD}, {ST_SWITCHED, ST_SOD}, {ST_QSTOP, ST_SOD}: begin
        t.clr_mask = CW_FAULT_RESET | CW_EN_VOLTAGE;
      end
      {ST_START, ST_NOT_READY}, {ST_NOT_READY, ST_SOD}, {ST_FAULT_REAC, ST_FAULT}: begin
        t.found = 1'b1;
      end
      {ST_SOD, ST_READY}, {ST_SWITCHED, ST_READY}, {ST_OPEN, ST_READY}: begin
        t.set_mask = CW_QUICK_STOP | CW_EN_VOLTAGE;
        t.clr_mask = CW_FAULT_RESET | CW_SWITCH_ON;
      end
      {ST_READY, ST_SWITCHED}, {ST_OPEN, ST_SWITCHED}: begin
        t.set_mask = CW_QUICK_STOP | CW_EN_VOLTAGE | CW_SWITCH_ON;
        t.clr_mask = CW_FAULT_RESET | CW_EN_OP;
      end
      {ST_SWITCHED, ST_OPEN}, {ST_QSTOP, ST_OPEN}: begin
        t.set_mask = CW_QUICK_STOP | CW_EN_VOLTAGE | CW_SWITCH_ON | CW_EN_OP;
        t.clr_mask = CW_FAULT_RESET;
      end
      {ST_READY, ST_QSTOP}, {ST_SWITCHED, ST_QSTOP}, {ST_OPEN, ST_QSTOP}: begin
        t.set_mask = CW_EN_VOLTAGE;
        t.clr_mask = CW_FAULT_RESET | CW_QUICK_STOP;
      end
      {ST_FAULT, ST_SOD}: begin
        t.set_mask = CW_FAULT_RESET;
      end
      default: begin
        t.found = 1'b0;
      end
    endcase
    return t;
  endfunction

endpackage

/* src/dscw_lookup.sv */
// ----------------------------------------------------------------------------
// dscw_lookup
// Hop planning and transition table lookup for one registered request item.
// ----------------------------------------------------------------------------
module dscw_lookup
  import dscw_pkg::*;
(
  input  req_t cmd,
  output rsp_t res
);

  hop_t   hop_sel;
  trans_t tr;
  logic   planned;
  logic   same;
  logic [3:0] hop;

  always_comb begin
    same    = (cmd.from_state == cmd.target_state);
    planned = cmd.step_mode && !same &&
              (cmd.target_state == ST_OPEN || cmd.target_state == ST_SOD);
    hop_sel = (cmd.target_state == ST_OPEN) ? hop_enable(cmd.from_state)
                                            : hop_disable(cmd.from_state);
    hop     = (planned && hop_sel.found) ? hop_sel.state : cmd.target_state;
    tr      = trans_lookup(cmd.from_state, hop);

    res.hop_state        = hop;
    res.new_control_word = cmd.control_word;
    if (same) begin
      res.ok = 1'b1;
    end else if (planned && !hop_sel.found) begin
      res.ok = 1'b0;
    end else begin
      res.ok = tr.found;
      if (tr.found) begin
        res.new_control_word = (cmd.control_word & ~tr.clr_mask) | tr.set_mask;
      end
    end
  end

endmodule

/* src/drive_state_controlword_step.sv */
// ----------------------------------------------------------------------------
// drive_state_controlword_step
// Control word for one drive state transition, input and result registered.
// The input register takes the request, the result register then its result.
// Throughput: one item per cycle, set by the input and result register pair,
// while the result is not stalled. A waiting result blocks requests only once
// the input register also holds an item.
// Reset: synchronous, clears both valid flags; the data registers are not reset.
// ----------------------------------------------------------------------------
module drive_state_controlword_step
  import dscw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic s1_valid;
  req_t s1;
  rsp_t res_next;
  logic s2_load;
  logic s1_load;

  assign s2_load   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s2_load;
  assign s1_load   = req_valid && !req_stall;

  dscw_lookup u_lookup (
    .cmd (s1),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      rsp <= res_next;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid && rsp_valid && rsp_stall)
    else $error("request stalled with room in the pipeline");

  a_fail_keeps_word: assert property (@(posedge clk) disable iff (rst)
    s2_load |=> rsp.ok || rsp.new_control_word == $past(s1.control_word))
    else $error("failed transition changed the control word");

  a_same_state_ok: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1.from_state == s1.target_state |=>
      rsp.ok && rsp.hop_state == $past(s1.target_state) &&
      rsp.new_control_word == $past(s1.control_word))
    else $error("equal states not passed through");

  a_no_plan_hop: assert property (@(posedge clk) disable iff (rst)
    s2_load && !s1.step_mode |=> rsp.hop_state == $past(s1.target_state))
    else $error("hop differs from target without step mode");

endmodule

/* bench/tb_drive_state_controlword_step.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drive_state_controlword_step
// Self-checking bench for the drive state control word block. A scoreboard
// class predicts each result from the accepted request. It covers hop
// planning and the transition masks, and compares the results in order.
// Directed requests walk every transition and corner case. Random requests
// follow, with bursts of idle and stall on both channels but for the last QUIET_ITEMS.
// ----------------------------------------------------------------------------
module tb_drive_state_controlword_step;
  import dscw_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 7;
  localparam int RANDOM_ITEMS   = 450;
  localparam int QUIET_ITEMS    = 80;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  class controlword_scoreboard;
    rsp_t pending_words[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function bit next_hop(logic [3:0] from, bit toward_enable, output logic [3:0] hop);
      bit found;
      found = 1'b1;
      hop   = ST_START;
      case (from)
        ST_START:      hop = ST_NOT_READY;
        ST_NOT_READY:  hop = ST_SOD;
        ST_SOD:        hop = toward_enable ? ST_READY : ST_SOD;
        ST_READY:      hop = toward_enable ? ST_SWITCHED : ST_SOD;
        ST_SWITCHED:   hop = toward_enable ? ST_OPEN : ST_READY;
        ST_OPEN:       hop = toward_enable ? ST_OPEN : ST_SWITCHED;
        ST_QSTOP: begin
          if (toward_enable) hop = ST_OPEN;
          else found = 1'b0;
        end
        ST_FAULT_REAC: hop = ST_FAULT;
        ST_FAULT:      hop = ST_SOD;
        default:       found = 1'b0;
      endcase
      return found;
    endfunction

    function bit find_transition(logic [3:0] from, logic [3:0] to,
                                 output logic [15:0] set_m, output logic [15:0] clr_m);
      bit found;
      found = 1'b1;
      set_m = '0;
      clr_m = '0;
      case ({from, to})
        {ST_READY, ST_SOD}, {ST_OPEN, ST_SOD}, {ST_SWITCHED, ST_SOD}, {ST_QSTOP, ST_SOD}:
          clr_m = CW_FAULT_RESET | CW_EN_VOLTAGE;
        {ST_START, ST_NOT_READY}, {ST_NOT_READY, ST_SOD}, {ST_FAULT_REAC, ST_FAULT}: ;
        {ST_SOD, ST_READY}, {ST_SWITCHED, ST_READY}, {ST_OPEN, ST_READY}: begin
          set_m = CW_QUICK_STOP | CW_EN_VOLTAGE;
          clr_m = CW_FAULT_RESET | CW_SWITCH_ON;
        end
        {ST_READY, ST_SWITCHED}, {ST_OPEN, ST_SWITCHED}: begin
          set_m = CW_QUICK_STOP | CW_EN_VOLTAGE | CW_SWITCH_ON;
          clr_m = CW_FAULT_RESET | CW_EN_OP;
        end
        {ST_SWITCHED, ST_OPEN}, {ST_QSTOP, ST_OPEN}: begin
          set_m = CW_QUICK_STOP | CW_EN_VOLTAGE | CW_SWITCH_ON | CW_EN_OP;
          clr_m = CW_FAULT_RESET;
        end
        {ST_READY, ST_QSTOP}, {ST_SWITCHED, ST_QSTOP}, {ST_OPEN, ST_QSTOP}: begin
          set_m = CW_EN_VOLTAGE;
          clr_m = CW_FAULT_RESET | CW_QUICK_STOP;
        end
        {ST_FAULT, ST_SOD}:
          set_m = CW_FAULT_RESET;
        default:
          found = 1'b0;
      endcase
      return found;
    endfunction

    function rsp_t predict_transition(req_t r);
      rsp_t        p;
      logic [3:0]  hop;
      logic [15:0] set_m;
      logic [15:0] clr_m;
      bit          good;
      p.new_control_word = r.control_word;
      p.hop_state        = r.target_state;
      p.ok               = 1'b1;
      if (r.from_state != r.target_state) begin
        good = 1'b1;
        if (r.step_mode && (r.target_state == ST_OPEN || r.target_state == ST_SOD)) begin
          good = next_hop(r.from_state, r.target_state == ST_OPEN, hop);
          if (good) p.hop_state = hop;
        end
        if (good) good = find_transition(r.from_state, p.hop_state, set_m, clr_m);
        if (good) p.new_control_word = (r.control_word & ~clr_m) | set_m;
        p.ok = good;
      end
      return p;
    endfunction

    function void note_request(req_t r);
      pending_words.push_back(predict_transition(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.new_control_word !== want.new_control_word) begin
        $error("new_control_word expected %h actual %h",
               want.new_control_word, got.new_control_word);
        errors++;
      end
      if (got.hop_state !== want.hop_state) begin
        $error("hop_state expected %0d actual %0d", want.hop_state, got.hop_state);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok expected %0d actual %0d", want.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  controlword_scoreboard words;
  bit idle_on;
  bit stall_on;
  int stall_left;
  int quiet_cycles;

  drive_state_controlword_step dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) words.note_request(req);
    if (!rst && rsp_valid && !rsp_stall) words.check_response(rsp);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp_stall = 1'b0;
    end else if (stall_left > 0) begin
      rsp_stall = 1'b1;
      stall_left--;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      rsp_stall  = 1'b1;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      rsp_stall = 1'b0;
    end
  end

  function automatic req_t make_req(logic [15:0] cw, logic [3:0] from, logic [3:0] to,
                                    logic step);
    req_t r;
    r.control_word = cw;
    r.from_state   = from;
    r.target_state = to;
    r.step_mode    = step;
    return r;
  endfunction

  task automatic push_request(req_t r);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = r;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  function automatic req_t random_req();
    req_t    r;
    int      pick;
    r.control_word = 16'($urandom);
    r.step_mode    = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.from_state   = 4'($urandom_range(ST_START, ST_FAULT));
      r.target_state = 4'($urandom_range(ST_START, ST_FAULT));
    end else if (pick < 75) begin
      r.from_state   = 4'($urandom_range(ST_START, ST_FAULT));
      r.target_state = $urandom_range(0, 1) ? ST_OPEN : ST_SOD;
      r.step_mode    = 1'b1;
    end else if (pick < 85) begin
      r.from_state   = 4'($urandom);
      r.target_state = r.from_state;
    end else begin
      r.from_state   = 4'($urandom);
      r.target_state = 4'($urandom);
    end
    return r;
  endfunction

  initial begin
    words      = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    rsp_stall  = 1'b0;
    stall_left = 0;
    quiet_cycles = 0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // every table transition, word alternating between both extremes
    push_request(make_req(16'h0000, ST_READY,      ST_SOD,       1'b0));
    push_request(make_req(16'hFFFF, ST_OPEN,       ST_SOD,       1'b0));
    push_request(make_req(16'h0000, ST_SWITCHED,   ST_SOD,       1'b0));
    push_request(make_req(16'hFFFF, ST_QSTOP,      ST_SOD,       1'b0));
    push_request(make_req(16'h0000, ST_START,      ST_NOT_READY, 1'b0));
    push_request(make_req(16'hFFFF, ST_NOT_READY,  ST_SOD,       1'b0));
    push_request(make_req(16'h0000, ST_FAULT_REAC, ST_FAULT,     1'b0));
    push_request(make_req(16'hFFFF, ST_SOD,        ST_READY,     1'b0));
    push_request(make_req(16'h0000, ST_SWITCHED,   ST_READY,     1'b0));
    push_request(make_req(16'hFFFF, ST_OPEN,       ST_READY,     1'b0));
    push_request(make_req(16'h0000, ST_READY,      ST_SWITCHED,  1'b0));
    push_request(make_req(16'hFFFF, ST_OPEN,       ST_SWITCHED,  1'b0));
    push_request(make_req(16'h0000, ST_SWITCHED,   ST_OPEN,      1'b0));
    push_request(make_req(16'hFFFF, ST_QSTOP,      ST_OPEN,      1'b0));
    push_request(make_req(16'h0000, ST_READY,      ST_QSTOP,     1'b0));
    push_request(make_req(16'hFFFF, ST_SWITCHED,   ST_QSTOP,     1'b0));
    push_request(make_req(16'h0000, ST_OPEN,       ST_QSTOP,     1'b0));
    push_request(make_req(16'hFFFF, ST_FAULT,      ST_SOD,       1'b0));
    // equal illegal states, missing hops, hop planning, pair not in table
    push_request(make_req(16'hA5A5, 4'd15,         4'd15,        1'b1));
    push_request(make_req(16'h5A5A, 4'd12,         ST_OPEN,      1'b1));
    push_request(make_req(16'hFFFF, ST_QSTOP,      ST_SOD,       1'b1));
    push_request(make_req(16'h0000, ST_START,      ST_OPEN,      1'b1));
    push_request(make_req(16'h1234, ST_FAULT,      ST_SOD,       1'b1));
    push_request(make_req(16'hFFFF, ST_START,      ST_FAULT,     1'b0));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      push_request(random_req());
    end
    req_valid = 1'b0;

    while (words.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (words.errors == 0 && words.pending_words.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
